### rtl/core/lcrc_pkg.sv
`timescale 1ns / 1ps

package lcrc_pkg;

    // code for the laser off (inverted dac)
    localparam logic [15:0] CODE_OFF = 16'hFFFF;

    // configuration reset values
    localparam logic [15:0] RAMP_STEP_RST   = 16'd64;
    localparam logic [15:0] ERR_MARGIN_RST  = 16'd980;
    localparam logic [7:0]  ERR_LIMIT_RST   = 8'd10;
    localparam logic [7:0]  ERR_COUNT_MAX   = 8'hFF;

    // configuration register indexes
    localparam int          CFG_IDX_W       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT  = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // host bus commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // host write addresses
    localparam logic [2:0] WADDR_ENABLE = 3'd0;
    localparam logic [2:0] WADDR_TARGET = 3'd1;
    localparam logic [2:0] WADDR_THR1   = 3'd2;
    localparam logic [2:0] WADDR_THR2   = 3'd3;

    // host read addresses
    localparam logic [2:0] RADDR_MONITOR = 3'd0;
    localparam logic [2:0] RADDR_ERRORS  = 3'd1;
    localparam logic [2:0] RADDR_THR1    = 3'd2;
    localparam logic [2:0] RADDR_TARGET  = 3'd3;
    localparam logic [2:0] RADDR_ENABLE  = 3'd4;

    // classified operation
    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_WR_ENABLE,
        OP_WR_TARGET,
        OP_WR_THR1,
        OP_WR_THR2,
        OP_READ
    } op_t;

    // read source
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_MONITOR,
        RD_ERRORS,
        RD_THR1,
        RD_TARGET,
        RD_ENABLE
    } rd_sel_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  reg_addr;
        logic [15:0] write_data;
        logic [15:0] monitor_current;
    } in_word_t;

    typedef struct packed {
        logic [15:0] dac_code;
        logic        ld_enable;
        logic        ramping;
        logic        out_error;
        logic        init_done;
        logic [15:0] read_data;
    } out_word_t;

    // queued operation, data field carries write data or monitor sample
    typedef struct packed {
        op_t         op;
        rd_sel_t     rd_sel;
        logic [15:0] data;
    } op_word_t;

    // queue handshake toward the back part
    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

### rtl/core/laser_current_ramp_controller_unit.sv
`timescale 1ns / 1ps
// Laser-diode current ramp controller.
// Input channel s_valid/s_ready/s_word carries one word per control tick,
// host register write or host register read. Every accepted word returns
// exactly one result word on m_valid/m_ready/m_word with the ramped dac
// code, status flags and, for reads, the register data.
// Configuration (ramp step, error margin, error count limit) is written by the user
// via cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
// An accepted word is stored in the queue, then executes into the result register
// once that register is free or its result is being taken.
// Throughput: one word per cycle while m_ready stays high; the execute stage
// updates the ramp and the error counter.
// Reset (aresetn low, synchronous) clears the queue and the result valid flag
// and loads the power-up register values; the laser code is off.
// When the receiver stalls, the result stays held, the two-entry queue
// fills and s_ready drops only once it is full.

module laser_current_ramp_controller_unit
    import lcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_word
);

    op_word_t      op_word;
    op_word_t      head_word;
    queue_status_t status;
    logic          push;
    logic          pop;

    assign s_ready = !status.full;
    assign push    = s_valid && s_ready;

    // decode
    lcrc_front u_front (
        .in_word (s_word),
        .op_word (op_word)
    );

    // decoupling queue
    lcrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (op_word),
        .pop       (pop),
        .head_word (head_word),
        .status    (status)
    );

    // execute and result register
    lcrc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head_word (head_word),
        .status    (status),
        .pop       (pop),
        .m_word    (m_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule

### rtl/core/lcrc_front.sv
`timescale 1ns / 1ps

module lcrc_front
    import lcrc_pkg::*;
(
    input  in_word_t in_word,
    output op_word_t op_word
);

    // classify command and address into one operation
    always_comb begin
        op_word.op     = OP_NOP;
        op_word.rd_sel = RD_ZERO;
        op_word.data   = in_word.write_data;
        unique case (cmd_t'(in_word.command))
            CMD_TICK: begin
                op_word.op   = OP_TICK;
                op_word.data = in_word.monitor_current;
            end
            CMD_WRITE: begin
                unique case (in_word.reg_addr)
                    WADDR_ENABLE: op_word.op = OP_WR_ENABLE;
                    WADDR_TARGET: op_word.op = OP_WR_TARGET;
                    WADDR_THR1:   op_word.op = OP_WR_THR1;
                    WADDR_THR2:   op_word.op = OP_WR_THR2;
                    default:      op_word.op = OP_NOP;
                endcase
            end
            CMD_READ: begin
                op_word.op = OP_READ;
                unique case (in_word.reg_addr)
                    RADDR_MONITOR: op_word.rd_sel = RD_MONITOR;
                    RADDR_ERRORS:  op_word.rd_sel = RD_ERRORS;
                    RADDR_THR1:    op_word.rd_sel = RD_THR1;
                    RADDR_TARGET:  op_word.rd_sel = RD_TARGET;
                    RADDR_ENABLE:  op_word.rd_sel = RD_ENABLE;
                    default:       op_word.rd_sel = RD_ZERO;
                endcase
            end
            default: op_word.op = OP_NOP;
        endcase
    end

endmodule

### rtl/core/lcrc_queue.sv
`timescale 1ns / 1ps

module lcrc_queue
    import lcrc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  op_word_t      push_word,
    input  logic          pop,
    output op_word_t      head_word,
    output queue_status_t status
);

    op_word_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    // pointer wrap helper
    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_word    = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### rtl/core/lcrc_back.sv
`timescale 1ns / 1ps

module lcrc_back
    import lcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  op_word_t             head_word,
    input  queue_status_t        status,
    output logic                 pop,
    output out_word_t            m_word,
    output logic                 m_valid,
    input  logic                 m_ready
);

    // configuration
    logic [15:0] ramp_step_reg;
    logic [15:0] err_margin_reg;
    logic [7:0]  err_limit_reg;

    // controller state
    logic [15:0] target_reg,  target_next;
    logic [15:0] ramp_reg,    ramp_next;
    logic [7:0]  enable_reg,  enable_next;
    logic [7:0]  thr1_reg,    thr1_next;
    logic        init_reg,    init_next;
    logic [15:0] monitor_reg, monitor_next;
    logic [7:0]  err_cnt_reg, err_cnt_next;
    logic        err_reg,     err_next;

    out_word_t   out_reg, out_next;
    logic        out_valid_reg;

    // tick datapath
    logic [15:0] goal;
    logic [15:0] goal_span;
    logic [15:0] stepped;
    logic [15:0] ramp_tick;
    logic [15:0] set_current;
    logic [15:0] cur_diff;
    logic [15:0] rd_value;

    assign pop     = status.valid && (!out_valid_reg || m_ready);
    assign m_word  = out_reg;
    assign m_valid = out_valid_reg;

    // ramp toward goal by at most one step
    always_comb begin
        goal = (enable_reg != '0) ? target_reg : CODE_OFF;
        if (goal > ramp_reg) begin
            goal_span = goal - ramp_reg;
            stepped   = ramp_reg + ramp_step_reg;
        end else begin
            goal_span = ramp_reg - goal;
            stepped   = ramp_reg - ramp_step_reg;
        end
        ramp_tick   = (goal_span > ramp_step_reg) ? stepped : goal;
        set_current = CODE_OFF - ramp_tick;
        cur_diff    = (set_current >= head_word.data) ? (set_current - head_word.data)
                                                      : (head_word.data - set_current);
    end

    // read mux
    always_comb begin
        unique case (head_word.rd_sel)
            RD_MONITOR: rd_value = monitor_reg;
            RD_ERRORS:  rd_value = {15'd0, err_reg};
            RD_THR1:    rd_value = {8'd0, thr1_reg};
            RD_TARGET:  rd_value = target_reg;
            RD_ENABLE:  rd_value = {8'd0, enable_reg};
            default:    rd_value = '0;
        endcase
    end

    // execute the queued operation
    always_comb begin
        target_next  = target_reg;
        ramp_next    = ramp_reg;
        enable_next  = enable_reg;
        thr1_next    = thr1_reg;
        init_next    = init_reg;
        monitor_next = monitor_reg;
        err_cnt_next = err_cnt_reg;
        err_next     = err_reg;
        out_next     = out_reg;
        if (pop) begin
            out_next.ld_enable = (ramp_reg != CODE_OFF);
            out_next.ramping   = 1'b0;
            out_next.read_data = '0;
            unique case (head_word.op)
                OP_TICK: begin
                    out_next.ramping = (goal != ramp_reg);
                    ramp_next        = ramp_tick;
                    monitor_next     = head_word.data;
                    if (cur_diff > err_margin_reg) begin
                        if (err_cnt_reg != ERR_COUNT_MAX) begin
                            err_cnt_next = err_cnt_reg + 1'b1;
                        end
                    end else begin
                        err_cnt_next = '0;
                    end
                    if (err_cnt_next > err_limit_reg) begin
                        err_next = 1'b1;
                    end
                end
                OP_WR_ENABLE: enable_next = head_word.data[7:0];
                OP_WR_TARGET: target_next = head_word.data;
                OP_WR_THR1:   thr1_next   = head_word.data[7:0];
                OP_WR_THR2:   init_next   = 1'b1;
                OP_READ:      out_next.read_data = rd_value;
                default:      ;
            endcase
            out_next.dac_code  = ramp_next;
            out_next.out_error = err_next;
            out_next.init_done = init_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg  <= RAMP_STEP_RST;
            err_margin_reg <= ERR_MARGIN_RST;
            err_limit_reg  <= ERR_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RAMP_STEP:  ramp_step_reg  <= cfg_data;
                CFG_ERR_MARGIN: err_margin_reg <= cfg_data;
                CFG_ERR_LIMIT:  err_limit_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= CODE_OFF;
            ramp_reg      <= CODE_OFF;
            enable_reg    <= '0;
            thr1_reg      <= '0;
            init_reg      <= 1'b0;
            monitor_reg   <= '0;
            err_cnt_reg   <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            target_reg    <= target_next;
            ramp_reg      <= ramp_next;
            enable_reg    <= enable_next;
            thr1_reg      <= thr1_next;
            init_reg      <= init_next;
            monitor_reg   <= monitor_next;
            err_cnt_reg   <= err_cnt_next;
            err_reg       <= err_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule
